### rtl/core/positional_insert_remove_list_macros.svh
// Assertion macros used by the checker of the positional list.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef POSITIONAL_INSERT_REMOVE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PIRL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pirl checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define PIRL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pirl checker: next-cycle implication failed");

`endif

### rtl/core/pirl_pkg.sv
// Shared types and constants of the positional insert/remove list.
// Depends on nothing; used by every module of the block.
package pirl_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 5;
  localparam int ERR_W    = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND      = 3'd0,
    KIND_INSERT      = 3'd1,
    KIND_REMOVE_LAST = 3'd2,
    KIND_REMOVE_AT   = 3'd3,
    KIND_READ        = 3'd4,
    KIND_OVERWRITE   = 3'd5
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_FULL  = 2'd3
  } err_t;

  // Command broadcast to the row of cells for one transfer.
  typedef struct packed {
    logic shift_up;    // cells above the index take their lower neighbor
    logic shift_down;  // cells at and above the index take their upper neighbor
    logic write;       // cell at the index takes the incoming handle
    logic take;        // the handle at the index is returned
  } cell_op_t;

endpackage

### rtl/core/pirl_cell.sv
// One storage cell of the list: holds one handle and moves it to a neighbor.
// Depends on pirl_pkg for the broadcast command type.
module pirl_cell #(
  parameter int HANDLE_BITS = 32,
  parameter int IDX_W       = 4,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  pirl_pkg::cell_op_t     op,
  input  logic [IDX_W-1:0]       at,
  input  logic [HANDLE_BITS-1:0] handle,
  input  logic [HANDLE_BITS-1:0] from_lower,
  input  logic [HANDLE_BITS-1:0] from_upper,
  output logic [HANDLE_BITS-1:0] value
);

  localparam logic [IDX_W-1:0] SELF = IDX_W'(INDEX);

  logic hit;
  logic above;

  assign hit   = (at == SELF);
  assign above = (SELF > at);

  always_ff @(posedge clk) begin
    priority if ((op.write || op.shift_up) && hit) begin
      value <= handle;
    end else if (op.shift_up && above) begin
      value <= from_lower;
    end else if (op.shift_down && (hit || above)) begin
      value <= from_upper;
    end else begin
      // No move touches this cell, so it keeps its handle.
      value <= value;
    end
  end

endmodule

### rtl/core/pirl_ctrl.sv
// Command decode and count bookkeeping of the list: checks each operation
// against the current count and builds the command for the cells.
// Depends on pirl_pkg.
module pirl_ctrl #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic [pirl_pkg::KIND_W-1:0] kind,
  input  logic [pirl_pkg::POS_W-1:0]  position,
  input  logic [CNT_W-1:0]            count,
  output pirl_pkg::cell_op_t          op,
  output logic [IDX_W-1:0]            at,
  output logic [CNT_W-1:0]            count_next,
  output pirl_pkg::err_t              err
);

  localparam int CMP_W = (CNT_W > pirl_pkg::POS_W) ? CNT_W : pirl_pkg::POS_W;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             empty;
  logic             full;
  logic [CNT_W-1:0] cnt_dec;

  assign pos_x   = CMP_W'(position);
  assign cnt_x   = CMP_W'(count);
  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign cnt_dec = count - CNT_W'(1);

  always_comb begin
    op         = '0;
    at         = IDX_W'(position);
    count_next = count;
    err        = pirl_pkg::ERR_OK;
    unique case (kind)
      pirl_pkg::KIND_APPEND: begin
        at = IDX_W'(count);
        if (full) begin
          err = pirl_pkg::ERR_FULL;
        end else begin
          op.write   = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      pirl_pkg::KIND_INSERT: begin
        if (pos_x > cnt_x) begin
          err = pirl_pkg::ERR_INDEX;
        end else if (full) begin
          err = pirl_pkg::ERR_FULL;
        end else begin
          op.shift_up = 1'b1;
          count_next  = count + CNT_W'(1);
        end
      end
      pirl_pkg::KIND_REMOVE_LAST: begin
        at = IDX_W'(cnt_dec);
        if (empty) begin
          err = pirl_pkg::ERR_EMPTY;
        end else begin
          op.take    = 1'b1;
          count_next = cnt_dec;
        end
      end
      pirl_pkg::KIND_REMOVE_AT, pirl_pkg::KIND_READ, pirl_pkg::KIND_OVERWRITE: begin
        if (empty) begin
          err = pirl_pkg::ERR_EMPTY;
        end else if (pos_x >= cnt_x) begin
          err = pirl_pkg::ERR_INDEX;
        end else if (kind == pirl_pkg::KIND_REMOVE_AT) begin
          op.take       = 1'b1;
          op.shift_down = 1'b1;
          count_next    = cnt_dec;
        end else if (kind == pirl_pkg::KIND_READ) begin
          op.take = 1'b1;
        end else begin
          op.write = 1'b1;
        end
      end
      default: begin
        // Unused kinds do nothing and report success.
      end
    endcase
  end

endmodule

### rtl/core/positional_insert_remove_list.sv
// Positional insert/remove list: an ordered list of up to DEPTH handles kept
// in a row of storage cells, with one command transfer in and one result
// transfer out per operation. Each operation (append, insert at an index,
// remove the last entry, remove at an index, read, overwrite) takes effect on
// the edge that accepts it: every cell looks at the broadcast command and in the
// same edge keeps its handle, takes the new handle, or takes the handle of its
// lower or upper neighbor, so an insert or removal anywhere in the list moves
// all later entries at once. The result (removed or read handle, the new count,
// an empty flag and an error code) sits in an output register, and a new
// command is taken whenever that register is free or is being emptied in the
// same cycle, so while out_ready is high the list takes one operation per cycle.
// Operations that report an error leave the list untouched. Storage cells are
// not reset; only entries below the current count are ever read.
// Depends on pirl_pkg, pirl_ctrl and pirl_cell.
module positional_insert_remove_list #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pirl_pkg::KIND_W-1:0]   kind,
  input  logic [pirl_pkg::POS_W-1:0]    position,
  input  logic [pirl_pkg::HANDLE_W-1:0] handle_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pirl_pkg::HANDLE_W-1:0] handle_out,
  output logic [pirl_pkg::COUNT_W-1:0]  count_now,
  output logic                          is_empty,
  output logic [pirl_pkg::ERR_W-1:0]    error_code
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // Count of valid entries; the only list state that reset clears.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic               in_fire;
  pirl_pkg::cell_op_t dec_op;
  pirl_pkg::cell_op_t op;
  logic [IDX_W-1:0]   at;
  pirl_pkg::err_t     err;

  logic [HANDLE_BITS+pirl_pkg::HANDLE_W-1:0] handle_in_wide;
  logic [HANDLE_BITS-1:0]                    handle_cell;
  logic [HANDLE_BITS-1:0]                    cell_q [DEPTH];
  logic [HANDLE_BITS-1:0]                    read_q;
  logic [HANDLE_BITS+pirl_pkg::HANDLE_W-1:0] read_wide;
  logic [CNT_W+pirl_pkg::COUNT_W-1:0]        count_wide;

  // A new command is taken when the result register is empty or drains now.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  pirl_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .kind       (kind),
    .position   (position),
    .count      (count),
    .op         (dec_op),
    .at         (at),
    .count_next (count_next),
    .err        (err)
  );

  // Cells only move on an accepted transfer.
  assign op = in_fire ? dec_op : '0;

  // Fit the incoming handle to the stored width.
  assign handle_in_wide = {{HANDLE_BITS{1'b0}}, handle_in};
  assign handle_cell    = handle_in_wide[HANDLE_BITS-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] lower;
    logic [HANDLE_BITS-1:0] upper;

    // The bottom cell never shifts up and the top cell has nothing above it.
    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign upper = cell_q[i];
    end else begin : g_upper
      assign upper = cell_q[i+1];
    end

    pirl_cell #(
      .HANDLE_BITS (HANDLE_BITS),
      .IDX_W       (IDX_W),
      .INDEX       (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .at         (at),
      .handle     (handle_cell),
      .from_lower (lower),
      .from_upper (upper),
      .value      (cell_q[i])
    );
  end

  // The read index is always below the count when a handle is returned.
  assign read_q     = dec_op.take ? cell_q[at] : '0;
  assign read_wide  = {{pirl_pkg::HANDLE_W{1'b0}}, read_q};
  assign count_wide = {{pirl_pkg::COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loaded with each accepted command.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      handle_out <= read_wide[pirl_pkg::HANDLE_W-1:0];
      count_now  <= count_wide[pirl_pkg::COUNT_W-1:0];
      is_empty   <= (count_next == '0);
      error_code <= err;
    end
  end

endmodule

### rtl/core/pirl_checker.sv
// Port-level checker of the positional list, bound to the top level.
// Depends on pirl_pkg and positional_insert_remove_list_macros.svh.
`include "positional_insert_remove_list_macros.svh"

module pirl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pirl_pkg::HANDLE_W-1:0] handle_out,
  input logic [pirl_pkg::COUNT_W-1:0]  count_now,
  input logic                          is_empty,
  input logic [pirl_pkg::ERR_W-1:0]    error_code
);

  // A result held back by the consumer blocks new commands.
  `PIRL_ASSERT_IMP(a_stall_blocks_input, clk, rst, out_valid && !out_ready, !in_ready)

  // Failed operations never return a handle.
  `PIRL_ASSERT_IMP(a_error_no_handle, clk, rst, out_valid && (error_code != pirl_pkg::ERR_OK), handle_out == '0)

  // An empty-list error leaves the list empty.
  `PIRL_ASSERT_IMP(a_empty_error_flag, clk, rst, out_valid && (error_code == pirl_pkg::ERR_EMPTY), is_empty && (count_now == '0))

  // A stalled result keeps its payload.
  `PIRL_ASSERT_NXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(handle_out) && $stable(count_now) && $stable(error_code))

endmodule

bind positional_insert_remove_list pirl_checker u_pirl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .handle_out (handle_out),
  .count_now  (count_now),
  .is_empty   (is_empty),
  .error_code (error_code)
);
